### hw/rtl/brf_pkg.sv
// Shared types and constants for the Brent root finder block.
package brf_pkg;

    localparam int WORD_BITS_DEF     = 64;
    localparam int FRACTION_BITS_DEF = 40;
    localparam int COUNT_BITS_DEF    = 16;

    // Fixed widths of the iteration limit register and iterations_used field.
    localparam int LIMIT_BITS  = 16;
    localparam int STATUS_BITS = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ABS_TOL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REL_TOL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT   = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_EVAL      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_CONVERGED = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_SIGN   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_EXACT     = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_LIMIT     = 3'd4;

    localparam logic [63:0]           TOL_RESET   = 64'd1099511;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd100;

    typedef enum logic {
        MDU_MUL = 1'b0,
        MDU_DIV = 1'b1
    } mdu_op_t;

    typedef struct packed {
        logic    start;
        mdu_op_t op;
    } mdu_cmd_t;

endpackage

### hw/rtl/brf_mdu.sv
// Shared iterative saturating fixed-point multiply and divide unit.
module brf_mdu #(
    parameter int WORD_BITS     = brf_pkg::WORD_BITS_DEF,
    parameter int FRACTION_BITS = brf_pkg::FRACTION_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  brf_pkg::mdu_cmd_t           cmd,
    input  logic signed [WORD_BITS-1:0] opa,
    input  logic signed [WORD_BITS-1:0] opb,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] result
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int NW = W + F;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_FIN  = 3'b100
    } mstate_t;

    mstate_t           state_reg, state_next;
    brf_pkg::mdu_op_t  op_reg, op_next;
    logic              neg_reg, neg_next;
    logic [W-1:0]      ub_reg, ub_next;
    logic [W:0]        hi_reg, hi_next;
    logic [W-1:0]      mlo_reg, mlo_next;
    logic [NW-1:0]     num_reg, num_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [W-1:0]      res_reg, res_next;

    logic [W-1:0] ua, ub;
    logic [W:0]   msum, drem;
    logic         over;
    logic [W-1:0] mag, lim;

    assign ua = opa[W-1] ? (~opa + 1'b1) : opa;
    assign ub = opb[W-1] ? (~opb + 1'b1) : opb;

    always_comb
    begin
        msum = hi_reg + (mlo_reg[0] ? {1'b0, ub_reg} : '0);
        drem = {hi_reg[W-1:0], num_reg[NW-1]};
        if (op_reg == brf_pkg::MDU_MUL)
        begin
            over = |({hi_reg[W-1:0], mlo_reg} >> (F + W));
            mag  = W'({hi_reg[W-1:0], mlo_reg} >> F);
        end
        else
        begin
            over = |(num_reg >> W);
            mag  = num_reg[W-1:0];
        end
        lim = neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        ub_next    = ub_reg;
        hi_next    = hi_reg;
        mlo_next   = mlo_reg;
        num_next   = num_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (cmd.start)
                begin
                    op_next  = cmd.op;
                    neg_next = opa[W-1] ^ opb[W-1];
                    ub_next  = ub;
                    hi_next  = '0;
                    mlo_next = ua;
                    num_next = NW'(ua) << F;
                    cnt_next = (cmd.op == brf_pkg::MDU_MUL) ? CW'(W - 1) : CW'(NW - 1);
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                if (op_reg == brf_pkg::MDU_MUL)
                begin
                    hi_next  = {1'b0, msum[W:1]};
                    mlo_next = {msum[0], mlo_reg[W-1:1]};
                end
                else
                begin
                    if (drem >= {1'b0, ub_reg})
                    begin
                        hi_next  = drem - {1'b0, ub_reg};
                        num_next = {num_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        hi_next  = drem;
                        num_next = {num_reg[NW-2:0], 1'b0};
                    end
                end
                if (cnt_reg == '0)
                    state_next = M_FIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            M_FIN:
            begin
                if (over || (mag > lim))
                    res_next = neg_reg ? (~lim + 1'b1) : lim;
                else
                    res_next = neg_reg ? (~mag + 1'b1) : mag;
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        ub_reg  <= ub_next;
        hi_reg  <= hi_next;
        mlo_reg <= mlo_next;
        num_reg <= num_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### hw/rtl/brent_root_finder_step.sv
// Top level of the Brent bracketing root finder, one iteration per item.
//
// The block drives an external function evaluator. A start item (req_type 0)
// brings a bracket and the function values at both ends; each later item
// (req_type 1) brings the function value at the point asked for last. Every
// accepted start item, and every value item while a search is active, yields
// exactly one result: the next point to evaluate (status 0) or a finished
// answer (converged, no sign change, exact zero at an end, iteration limit).
// A value item while no search is active is dropped without a result. All
// values are signed fixed point with FRACTION_BITS fraction bits. An answer
// straight from the bracket is the quickest item; an inverse quadratic step
// (six multiplies and three divides) is the slowest, counted from acceptance
// until the next item can be accepted with the receiver ready. The time is
// set by the single shared multiply/divide unit, which retires one bit per
// cycle. A secant step needs one multiply and one divide beyond the
// tolerance multiply, bisection needs only the tolerance multiply.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next item can be taken before it is read.
// Configuration writes must only be made while the block is idle.
module brent_root_finder_step #(
    parameter int WORD_BITS     = brf_pkg::WORD_BITS_DEF,
    parameter int FRACTION_BITS = brf_pkg::FRACTION_BITS_DEF,
    parameter int COUNT_BITS    = brf_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [brf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [WORD_BITS-2:0]                  cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  req_type,
    input  logic signed [WORD_BITS-1:0]           x_low_end,
    input  logic signed [WORD_BITS-1:0]           x_high_end,
    input  logic signed [WORD_BITS-1:0]           f_low_end,
    input  logic signed [WORD_BITS-1:0]           f_high_end,
    input  logic signed [WORD_BITS-1:0]           f_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [WORD_BITS-1:0]           x_result,
    output logic [brf_pkg::STATUS_BITS-1:0]       status,
    output logic [brf_pkg::LIMIT_BITS-1:0]        iterations_used
);

    localparam int W    = WORD_BITS;
    localparam int LB   = brf_pkg::LIMIT_BITS;
    localparam int CMPW = (COUNT_BITS > LB) ? COUNT_BITS : LB;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef logic signed [W-1:0] word_t;

    typedef enum logic [18:0] {
        S_IDLE  = 19'h00001,
        S_CHECK = 19'h00002,
        S_SWAP  = 19'h00004,
        S_TOL   = 19'h00008,
        S_TOLW  = 19'h00010,
        S_CONV  = 19'h00020,
        S_SEC1  = 19'h00040,
        S_DIVW  = 19'h00080,
        S_IQ1   = 19'h00100,
        S_IQ2   = 19'h00200,
        S_IQ3   = 19'h00400,
        S_IQ4   = 19'h00800,
        S_IQ5   = 19'h01000,
        S_IQ6   = 19'h02000,
        S_IQ7   = 19'h04000,
        S_ACC   = 19'h08000,
        S_UPD   = 19'h10000,
        S_STEP  = 19'h20000,
        S_OUT   = 19'h40000
    } state_t;

    // Saturating helpers on the word.
    function automatic word_t sadd(input word_t a, input word_t b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic word_t ssub(input word_t a, input word_t b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
            return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic word_t sneg(input word_t a);
        return (a == WMIN) ? WMAX : -a;
    endfunction

    function automatic word_t sabs(input word_t a);
        return a[W-1] ? sneg(a) : a;
    endfunction

    function automatic logic [W-1:0] umag(input word_t a);
        return a[W-1] ? (~a + 1'b1) : a;
    endfunction

    // Halving that truncates toward zero.
    function automatic word_t half(input word_t a);
        word_t t;
        t = a + word_t'(a[W-1]);
        return t >>> 1;
    endfunction

    state_t state_reg, state_next;

    logic [W-2:0]      abs_tol_reg, rel_tol_reg;
    logic [LB-1:0]     limit_reg;

    word_t xp_reg, xp_next, xc_reg, xc_next, xk_reg, xk_next;
    word_t fp_reg, fp_next, fc_reg, fc_next, fk_reg, fk_next;
    word_t sp_reg, sp_next, sc_reg, sc_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic  active_reg, active_next;

    // Per-iteration scratch registers.
    word_t delta_reg, delta_next, sbis_reg, sbis_next, stry_reg, stry_next;
    word_t dpre_reg, dpre_next, dblk_reg, dblk_next;
    word_t tmp_reg, tmp_next, div_reg, div_next;
    logic  ok_reg, ok_next;

    word_t                         res_x_reg, res_x_next;
    logic [brf_pkg::STATUS_BITS-1:0] res_st_reg, res_st_next;

    logic                            out_valid_reg;
    word_t                           x_result_reg;
    logic [brf_pkg::STATUS_BITS-1:0] status_reg;
    logic [LB-1:0]                   iter_reg;

    brf_pkg::mdu_cmd_t mdu_cmd;
    word_t             mdu_a, mdu_b, mdu_res;
    logic              mdu_done;

    logic [CMPW-1:0] cnt_wide, limit_wide;
    word_t dx1, dx2, as_w, lim1, lim2, two, lmin;
    logic  emit_ok;

    brf_mdu #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mdu_cmd),
        .opa    (mdu_a),
        .opb    (mdu_b),
        .done   (mdu_done),
        .result (mdu_res)
    );

    assign cnt_wide   = CMPW'(cnt_reg);
    assign limit_wide = CMPW'(limit_reg);
    assign dx1        = ssub(xp_reg, xc_reg);
    assign dx2        = ssub(xk_reg, xc_reg);
    assign in_ready   = (state_reg == S_IDLE);
    assign emit_ok    = !out_valid_reg || out_ready;

    // Acceptance test of an interpolated step against the bisection bounds.
    always_comb
    begin
        as_w = sabs(sbis_reg);
        lim2 = ssub(sadd(sadd(as_w, as_w), as_w), delta_reg);
        lim1 = sabs(sp_reg);
        two  = sadd(sabs(stry_reg), sabs(stry_reg));
        lmin = (lim1 < lim2) ? lim1 : lim2;
    end

    always_comb
    begin
        state_next  = state_reg;
        xp_next     = xp_reg;
        xc_next     = xc_reg;
        xk_next     = xk_reg;
        fp_next     = fp_reg;
        fc_next     = fc_reg;
        fk_next     = fk_reg;
        sp_next     = sp_reg;
        sc_next     = sc_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        delta_next  = delta_reg;
        sbis_next   = sbis_reg;
        stry_next   = stry_reg;
        dpre_next   = dpre_reg;
        dblk_next   = dblk_reg;
        tmp_next    = tmp_reg;
        div_next    = div_reg;
        ok_next     = ok_reg;
        res_x_next  = res_x_reg;
        res_st_next = res_st_reg;
        mdu_cmd     = '{start: 1'b0, op: brf_pkg::MDU_MUL};
        mdu_a       = '0;
        mdu_b       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!req_type)
                    begin
                        xp_next     = x_low_end;
                        xc_next     = x_high_end;
                        fp_next     = f_low_end;
                        fc_next     = f_high_end;
                        xk_next     = '0;
                        fk_next     = '0;
                        sp_next     = '0;
                        sc_next     = '0;
                        cnt_next    = '0;
                        active_next = 1'b0;
                        state_next  = S_OUT;
                        if ((f_low_end != 0) && (f_high_end != 0)
                            && (f_low_end[W-1] == f_high_end[W-1]))
                        begin
                            res_x_next  = '0;
                            res_st_next = brf_pkg::ST_NO_SIGN;
                        end
                        else if (f_low_end == 0)
                        begin
                            res_x_next  = x_low_end;
                            res_st_next = brf_pkg::ST_EXACT;
                        end
                        else if (f_high_end == 0)
                        begin
                            res_x_next  = x_high_end;
                            res_st_next = brf_pkg::ST_EXACT;
                        end
                        else
                        begin
                            active_next = 1'b1;
                            state_next  = S_CHECK;
                        end
                    end
                    else if (active_reg)
                    begin
                        fc_next    = f_value;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (cnt_wide >= limit_wide)
                begin
                    active_next = 1'b0;
                    res_x_next  = xc_reg;
                    res_st_next = brf_pkg::ST_LIMIT;
                    state_next  = S_OUT;
                end
                else
                begin
                    // A sign change between the last two points moves the
                    // contrapoint to the previous point.
                    if ((fp_reg != 0) && (fc_reg != 0) && (fp_reg[W-1] != fc_reg[W-1]))
                    begin
                        xk_next = xp_reg;
                        fk_next = fp_reg;
                        sp_next = ssub(xc_reg, xp_reg);
                        sc_next = ssub(xc_reg, xp_reg);
                    end
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                if (umag(fk_reg) < umag(fc_reg))
                begin
                    xp_next = xc_reg;
                    xc_next = xk_reg;
                    xk_next = xc_reg;
                    fp_next = fc_reg;
                    fc_next = fk_reg;
                    fk_next = fc_reg;
                end
                state_next = S_TOL;
            end
            S_TOL:
            begin
                sbis_next   = half(ssub(xk_reg, xc_reg));
                mdu_cmd     = '{start: 1'b1, op: brf_pkg::MDU_MUL};
                mdu_a       = {1'b0, rel_tol_reg};
                mdu_b       = sabs(xc_reg);
                state_next  = S_TOLW;
            end
            S_TOLW:
            begin
                if (mdu_done)
                begin
                    delta_next = half(sadd({1'b0, abs_tol_reg}, mdu_res));
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                ok_next    = 1'b0;
                state_next = S_UPD;
                if ((fc_reg == 0) || (umag(sbis_reg) < umag(delta_reg)))
                begin
                    active_next = 1'b0;
                    res_x_next  = xc_reg;
                    res_st_next = brf_pkg::ST_CONVERGED;
                    state_next  = S_OUT;
                end
                else if ((umag(sp_reg) > umag(delta_reg)) && (umag(fc_reg) < umag(fp_reg)))
                begin
                    if (xp_reg == xk_reg)
                    begin
                        // Secant step.
                        if (ssub(fc_reg, fp_reg) != 0)
                        begin
                            div_next   = ssub(fc_reg, fp_reg);
                            mdu_cmd    = '{start: 1'b1, op: brf_pkg::MDU_MUL};
                            mdu_a      = fc_reg;
                            mdu_b      = ssub(xc_reg, xp_reg);
                            state_next = S_SEC1;
                        end
                    end
                    else if ((dx1 != 0) && (dx2 != 0))
                    begin
                        // Inverse quadratic step through divided differences.
                        mdu_cmd    = '{start: 1'b1, op: brf_pkg::MDU_DIV};
                        mdu_a      = ssub(fp_reg, fc_reg);
                        mdu_b      = dx1;
                        state_next = S_IQ1;
                    end
                end
            end
            S_SEC1:
            begin
                if (mdu_done)
                begin
                    mdu_cmd    = '{start: 1'b1, op: brf_pkg::MDU_DIV};
                    mdu_a      = mdu_res;
                    mdu_b      = div_reg;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (mdu_done)
                begin
                    stry_next  = sneg(mdu_res);
                    state_next = S_ACC;
                end
            end
            S_IQ1:
            begin
                if (mdu_done)
                begin
                    dpre_next  = mdu_res;
                    mdu_cmd    = '{start: 1'b1, op: brf_pkg::MDU_DIV};
                    mdu_a      = ssub(fk_reg, fc_reg);
                    mdu_b      = dx2;
                    state_next = S_IQ2;
                end
            end
            S_IQ2:
            begin
                if (mdu_done)
                begin
                    dblk_next  = mdu_res;
                    mdu_cmd    = '{start: 1'b1, op: brf_pkg::MDU_MUL};
                    mdu_a      = mdu_res;
                    mdu_b      = dpre_reg;
                    state_next = S_IQ3;
                end
            end
            S_IQ3:
            begin
                if (mdu_done)
                begin
                    mdu_cmd    = '{start: 1'b1, op: brf_pkg::MDU_MUL};
                    mdu_a      = mdu_res;
                    mdu_b      = ssub(fk_reg, fp_reg);
                    state_next = S_IQ4;
                end
            end
            S_IQ4:
            begin
                if (mdu_done)
                begin
                    div_next = mdu_res;
                    if (mdu_res == 0)
                    begin
                        state_next = S_UPD;
                    end
                    else
                    begin
                        mdu_cmd    = '{start: 1'b1, op: brf_pkg::MDU_MUL};
                        mdu_a      = fk_reg;
                        mdu_b      = dblk_reg;
                        state_next = S_IQ5;
                    end
                end
            end
            S_IQ5:
            begin
                if (mdu_done)
                begin
                    tmp_next   = mdu_res;
                    mdu_cmd    = '{start: 1'b1, op: brf_pkg::MDU_MUL};
                    mdu_a      = fp_reg;
                    mdu_b      = dpre_reg;
                    state_next = S_IQ6;
                end
            end
            S_IQ6:
            begin
                if (mdu_done)
                begin
                    mdu_cmd    = '{start: 1'b1, op: brf_pkg::MDU_MUL};
                    mdu_a      = fc_reg;
                    mdu_b      = ssub(tmp_reg, mdu_res);
                    state_next = S_IQ7;
                end
            end
            S_IQ7:
            begin
                if (mdu_done)
                begin
                    mdu_cmd    = '{start: 1'b1, op: brf_pkg::MDU_DIV};
                    mdu_a      = mdu_res;
                    mdu_b      = div_reg;
                    state_next = S_DIVW;
                end
            end
            S_ACC:
            begin
                ok_next    = (two < lmin);
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (ok_reg)
                begin
                    sp_next = sc_reg;
                    sc_next = stry_reg;
                end
                else
                begin
                    sp_next = sbis_reg;
                    sc_next = sbis_reg;
                end
                xp_next    = xc_reg;
                fp_next    = fc_reg;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                // Steps no larger than the tolerance are widened to it.
                if (umag(sc_reg) > umag(delta_reg))
                    xc_next = sadd(xc_reg, sc_reg);
                else
                    xc_next = sadd(xc_reg, (sbis_reg > 0) ? delta_reg : sneg(delta_reg));
                if (cnt_reg != {COUNT_BITS{1'b1}})
                    cnt_next = cnt_reg + 1'b1;
                res_x_next  = xc_next;
                res_st_next = brf_pkg::ST_EVAL;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (emit_ok)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            abs_tol_reg   <= (W-1)'(brf_pkg::TOL_RESET);
            rel_tol_reg   <= (W-1)'(brf_pkg::TOL_RESET);
            limit_reg     <= brf_pkg::LIMIT_RESET;
            xp_reg        <= '0;
            xc_reg        <= '0;
            xk_reg        <= '0;
            fp_reg        <= '0;
            fc_reg        <= '0;
            fk_reg        <= '0;
            sp_reg        <= '0;
            sc_reg        <= '0;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            xp_reg     <= xp_next;
            xc_reg     <= xc_next;
            xk_reg     <= xk_next;
            fp_reg     <= fp_next;
            fc_reg     <= fc_next;
            fk_reg     <= fk_next;
            sp_reg     <= sp_next;
            sc_reg     <= sc_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    brf_pkg::CFG_ABS_TOL: abs_tol_reg <= cfg_data;
                    brf_pkg::CFG_REL_TOL: rel_tol_reg <= cfg_data;
                    brf_pkg::CFG_LIMIT:   limit_reg   <= cfg_data[LB-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if ((state_reg == S_OUT) && emit_ok)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg  <= delta_next;
        sbis_reg   <= sbis_next;
        stry_reg   <= stry_next;
        dpre_reg   <= dpre_next;
        dblk_reg   <= dblk_next;
        tmp_reg    <= tmp_next;
        div_reg    <= div_next;
        ok_reg     <= ok_next;
        res_x_reg  <= res_x_next;
        res_st_reg <= res_st_next;
        if ((state_reg == S_OUT) && emit_ok)
        begin
            x_result_reg <= res_x_reg;
            status_reg   <= res_st_reg;
            iter_reg     <= cnt_wide[LB-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign x_result        = x_result_reg;
    assign status          = status_reg;
    assign iterations_used = iter_reg;

endmodule

### hw/rtl/brf_checker.sv
// Port-level checks for the Brent root finder and their bind.
module brf_checker #(
    parameter int WORD_BITS = brf_pkg::WORD_BITS_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               req_type,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [WORD_BITS-1:0]        x_result,
    input logic [brf_pkg::STATUS_BITS-1:0]    status,
    input logic [brf_pkg::LIMIT_BITS-1:0]     iterations_used
);

    // A pending result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_result) && $stable(status))
        else $error("result changed while stalled");

    // A start item always makes the block busy in the cycle after it is accepted.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !req_type |=> !in_ready)
        else $error("block ready right after a start item");

    // Bracket-only answers consume no evaluations.
    a_early_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == brf_pkg::ST_NO_SIGN || status == brf_pkg::ST_EXACT)
        |-> iterations_used == '0)
        else $error("bracket answer with nonzero count");

    // Status codes above the limit code are never produced.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= brf_pkg::ST_LIMIT)
        else $error("status out of range");

endmodule

bind brent_root_finder_step brf_checker #(
    .WORD_BITS (WORD_BITS)
) u_brf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .x_result        (x_result),
    .status          (status),
    .iterations_used (iterations_used)
);

### tb/sv/brent_root_finder_step_test.sv
// Self-checking testbench for the Brent root finder step block.
`timescale 1ns / 1ps

module brent_root_finder_step_test;

    typedef logic signed [63:0] word_t;

    localparam word_t WORD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam word_t WORD_MIN = 64'sh8000_0000_0000_0000;
    localparam word_t ONE      = 64'sh0000_0100_0000_0000;
    // Longest iteration plus margin, in cycles. Used before register writes
    // and at the end, since a dropped value item yields no result to wait on.
    localparam int SETTLE_CYCLES = 1000;

    // One result as the block should present it.
    typedef struct {
        word_t        x;
        logic [2:0]   st;
        logic [15:0]  used;
    } outcome_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [brf_pkg::CFG_IDX_BITS-1:0]  cfg_index = brf_pkg::CFG_ABS_TOL;
    logic [62:0]                       cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic                              req_type = 1'b0;
    word_t                             x_low_end = '0;
    word_t                             x_high_end = '0;
    word_t                             f_low_end = '0;
    word_t                             f_high_end = '0;
    word_t                             f_value = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    word_t                             x_result;
    logic [brf_pkg::STATUS_BITS-1:0]   status;
    logic [brf_pkg::LIMIT_BITS-1:0]    iterations_used;

    brent_root_finder_step DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .x_low_end(x_low_end), .x_high_end(x_high_end),
        .f_low_end(f_low_end), .f_high_end(f_high_end), .f_value(f_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .x_result(x_result), .status(status), .iterations_used(iterations_used)
    );

    always #4 clk = ~clk;

    // Predictor copy of the configuration registers.
    logic [62:0] tol_abs_m = 63'd1099511;
    logic [62:0] tol_rel_m = 63'd1099511;
    logic [15:0] eval_limit_m = 16'd100;

    // Predictor copy of the search state: previous point, current best point,
    // the contrapoint on the other side of the root, and the last two steps.
    word_t       xp = '0, xc = '0, xk = '0;
    word_t       fp = '0, fc = '0, fk = '0;
    word_t       step_old = '0, step_new = '0;
    logic [15:0] eval_count = '0;
    logic        searching = 1'b0;

    outcome_t    pending_results[$];
    outcome_t    last_answer;
    bit          last_answered;
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          status_seen[0:4] = '{default: 0};
    bit          no_idle = 0;

    // Test function used to answer evaluation requests: a slope through a
    // chosen root, optionally with a cubic term to bend it.
    word_t       fn_root, fn_slope;
    bit          fn_cubic;

    // ---------------------------------------------------------------
    // Saturating fixed-point arithmetic at the block's word width.
    // ---------------------------------------------------------------
    function automatic word_t sat_add(word_t a, word_t b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? WORD_MIN : WORD_MAX;
        return s[63:0];
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? WORD_MIN : WORD_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag(word_t a);
        return a[63] ? -a : a;
    endfunction

    function automatic word_t sat_neg(word_t a);
        return (a == WORD_MIN) ? WORD_MAX : -a;
    endfunction

    function automatic word_t sat_abs(word_t a);
        return a[63] ? sat_neg(a) : a;
    endfunction

    function automatic word_t signed_from_mag(bit neg, logic [63:0] m, bit over);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (over || m > lim)
            m = lim;
        return neg ? -m : m;
    endfunction

    function automatic word_t fx_mul(word_t a, word_t b);
        logic [127:0] p;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        return signed_from_mag(a[63] != b[63], p[103:40], |p[127:104]);
    endfunction

    // The divisor is never zero at any call site.
    function automatic word_t fx_div(word_t a, word_t b);
        logic [127:0] n, q;
        n = {64'd0, mag(a)} << 40;
        q = n / {64'd0, mag(b)};
        return signed_from_mag(a[63] != b[63], q[63:0], |q[127:64]);
    endfunction

    function automatic word_t half(word_t a);
        return a / 2;
    endfunction

    // ---------------------------------------------------------------
    // One Brent iteration on the predictor state.
    // ---------------------------------------------------------------
    function automatic void brent_iteration(output outcome_t o);
        word_t delta, bis, trial, den, num, dx1, dx2, dpre, dblk, lim1, lim2, twice, t;
        bit    interp_ok;
        interp_ok = 0;
        trial = '0;
        if (eval_count >= eval_limit_m) begin
            searching = 0;
            o = '{xc, brf_pkg::ST_LIMIT, eval_count};
            return;
        end
        // A sign change between the last two points makes the previous
        // point the new contrapoint.
        if (fp != 0 && fc != 0 && fp[63] != fc[63]) begin
            xk = xp;
            fk = fp;
            step_old = sat_sub(xc, xp);
            step_new = step_old;
        end
        if (mag(fk) < mag(fc)) begin
            xp = xc; xc = xk; xk = xp;
            fp = fc; fc = fk; fk = fp;
        end
        delta = half(sat_add({1'b0, tol_abs_m}, fx_mul({1'b0, tol_rel_m}, sat_abs(xc))));
        bis = half(sat_sub(xk, xc));
        if (fc == 0 || mag(bis) < mag(delta)) begin
            searching = 0;
            o = '{xc, brf_pkg::ST_CONVERGED, eval_count};
            return;
        end
        if (mag(step_old) > mag(delta) && mag(fc) < mag(fp)) begin
            if (xp == xk) begin
                // Secant step; equal ordinates force bisection.
                t = sat_sub(fc, fp);
                if (t != 0) begin
                    trial = sat_neg(fx_div(fx_mul(fc, sat_sub(xc, xp)), t));
                    interp_ok = 1;
                end
            end else begin
                // Inverse quadratic step through three distinct points.
                dx1 = sat_sub(xp, xc);
                dx2 = sat_sub(xk, xc);
                if (dx1 != 0 && dx2 != 0) begin
                    dpre = fx_div(sat_sub(fp, fc), dx1);
                    dblk = fx_div(sat_sub(fk, fc), dx2);
                    den = fx_mul(fx_mul(dblk, dpre), sat_sub(fk, fp));
                    if (den != 0) begin
                        num = fx_mul(fc, sat_sub(fx_mul(fk, dblk), fx_mul(fp, dpre)));
                        trial = sat_neg(fx_div(num, den));
                        interp_ok = 1;
                    end
                end
            end
            if (interp_ok) begin
                lim2 = sat_sub(sat_add(sat_add(sat_abs(bis), sat_abs(bis)),
                                       sat_abs(bis)), delta);
                lim1 = sat_abs(step_old);
                twice = sat_add(sat_abs(trial), sat_abs(trial));
                interp_ok = twice < ((lim1 < lim2) ? lim1 : lim2);
            end
        end
        if (interp_ok) begin
            step_old = step_new;
            step_new = trial;
        end else begin
            step_old = bis;
            step_new = bis;
        end
        xp = xc;
        fp = fc;
        if (mag(step_new) > mag(delta))
            xc = sat_add(xc, step_new);
        else
            xc = sat_add(xc, (bis > 0) ? delta : sat_neg(delta));
        if (eval_count != 16'hFFFF)
            eval_count++;
        o = '{xc, brf_pkg::ST_EVAL, eval_count};
    endfunction

    // Applies one accepted item to the predictor; returns 1 if it yields a result.
    function automatic bit predict_answer(logic req, word_t xl, word_t xh, word_t fl,
                                          word_t fh, word_t fv, output outcome_t o);
        o = '{'0, brf_pkg::ST_EVAL, '0};
        if (req == 1'b0) begin
            xp = xl; xc = xh; fp = fl; fc = fh;
            xk = '0; fk = '0;
            step_old = '0; step_new = '0;
            eval_count = '0;
            searching = 0;
            if (fp != 0 && fc != 0 && fp[63] == fc[63]) begin
                o = '{'0, brf_pkg::ST_NO_SIGN, eval_count};
                return 1;
            end
            if (fp == 0) begin
                o = '{xp, brf_pkg::ST_EXACT, eval_count};
                return 1;
            end
            if (fc == 0) begin
                o = '{xc, brf_pkg::ST_EXACT, eval_count};
                return 1;
            end
            searching = 1;
            brent_iteration(o);
            return 1;
        end
        if (!searching)
            return 0;
        fc = fv;
        brent_iteration(o);
        return 1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers.
    // ---------------------------------------------------------------
    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random signed value with magnitude below 2**bits.
    function automatic word_t rand_word(int bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (bits < 64)
            v = v & ((64'd1 << bits) - 64'd1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic word_t test_fn(word_t x);
        word_t d, f;
        d = sat_sub(x, fn_root);
        f = fx_mul(fn_slope, d);
        if (fn_cubic)
            f = sat_add(f, fx_mul(fx_mul(d, d), d));
        return f;
    endfunction

    // Sends one item. The previous item, if any, was accepted in this same
    // time step, so in_valid is lowered here only when a gap follows.
    task automatic send_item(logic req, word_t xl, word_t xh, word_t fl, word_t fh,
                             word_t fv);
        int       gap;
        outcome_t o;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        x_low_end <= xl;
        x_high_end <= xh;
        f_low_end <= fl;
        f_high_end <= fh;
        f_value <= fv;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        last_answered = predict_answer(req, xl, xh, fl, fh, fv, o);
        if (last_answered) begin
            last_answer = o;
            pending_results.push_back(o);
        end
    endtask

    task automatic send_start(word_t xl, word_t xh, word_t fl, word_t fh);
        send_item(1'b0, xl, xh, fl, fh, rand_word(64));
    endtask

    task automatic send_value(word_t fv);
        send_item(1'b1, rand_word(64), rand_word(64), rand_word(64), rand_word(64), fv);
    endtask

    // Waits until every expected result has come out and the block has had
    // time to finish an item that yields none.
    task automatic drain();
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [brf_pkg::CFG_IDX_BITS-1:0] idx, logic [62:0] data);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            brf_pkg::CFG_ABS_TOL: tol_abs_m = data;
            brf_pkg::CFG_REL_TOL: tol_rel_m = data;
            brf_pkg::CFG_LIMIT:   eval_limit_m = data[15:0];
            default: ;
        endcase
    endtask

    // Runs one search against the test function, answering each requested
    // point, until it finishes or the item cap is hit.
    task automatic run_search(word_t a, word_t b, int max_items);
        int n;
        send_start(a, b, test_fn(a), test_fn(b));
        n = 1;
        while (last_answered && last_answer.st == brf_pkg::ST_EVAL && n < max_items) begin
            send_value(test_fn(last_answer.x));
            n++;
        end
    endtask

    // Picks a random test function and a bracket around its root.
    task automatic random_search(int max_items);
        word_t a, b, span_lo, span_hi;
        int    scale;
        scale = ($urandom_range(0, 19) == 0) ? 60 : $urandom_range(30, 46);
        fn_root = rand_word(scale);
        fn_slope = rand_word($urandom_range(36, 44));
        if (fn_slope == 0)
            fn_slope = ONE;
        fn_cubic = $urandom_range(0, 2) == 0;
        span_lo = mag(rand_word(scale)) + 1;
        span_hi = mag(rand_word(scale)) + 1;
        a = sat_sub(fn_root, span_lo);
        b = sat_add(fn_root, span_hi);
        if ($urandom_range(0, 1))
            run_search(b, a, max_items);
        else
            run_search(a, b, max_items);
    endtask

    // ---------------------------------------------------------------
    // Result checker and receiver stalls.
    // ---------------------------------------------------------------
    int ready_hold = 0;

    always @(posedge clk) begin
        outcome_t e;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: x=%h status=%0d used=%0d",
                         $realtime, x_result, status, iterations_used);
            end else begin
                e = pending_results.pop_front();
                if (e.st <= brf_pkg::ST_LIMIT)
                    status_seen[e.st]++;
                if (x_result !== e.x) begin
                    errors++;
                    $display("%0t: x_result expected %h actual %h", $realtime, e.x, x_result);
                end
                if (status !== e.st) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $realtime, e.st, status);
                end
                if (iterations_used !== e.used) begin
                    errors++;
                    $display("%0t: iterations_used expected %0d actual %0d",
                             $realtime, e.used, iterations_used);
                end
            end
        end
        // Ready toggles between random stretches; with idling off it stays high.
        if (no_idle) begin
            out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if (out_ready) begin
            out_ready <= 1'b0;
            ready_hold = pick_gap();
        end else begin
            out_ready <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end
    end

    // ---------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------
    // Early finishes, extremes of the fields, restarts, forced bisection and
    // the iteration limit, mostly under the reset tolerances.
    task automatic test_edge_cases();
        // Same sign at both ends, positive and negative.
        send_start(-ONE, ONE, ONE, 5 * ONE);
        send_start(WORD_MIN, WORD_MAX, WORD_MIN, -1);
        // Exact zero at the low end wins over one at the high end.
        send_start(3 * ONE, 7 * ONE, 0, 0);
        send_start(3 * ONE, 7 * ONE, -ONE, 0);
        // A value item while idle is dropped.
        send_value(ONE);
        // Extreme ends and values, then one value item.
        send_start(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
        send_value(WORD_MAX);
        // Start while a search is active drops the old search.
        send_start(-ONE, 2 * ONE, -ONE, 2 * ONE);
        send_start(WORD_MAX, WORD_MIN, -1, 1);
        send_value(WORD_MIN);
        // Equal ordinates fail the decrease test for interpolation, forcing bisection.
        send_start(-4 * ONE, 4 * ONE, -ONE, ONE);
        send_value(-ONE);
        send_value(-ONE);
        send_value(-ONE);
        // Bracket narrower than the tolerance converges at once.
        send_start(ONE, ONE + 5, -ONE, ONE);
        // An exact zero at a requested point converges.
        send_start(-2 * ONE, 2 * ONE, -ONE, 3 * ONE);
        send_value(0);
        // Limit of one: first point is requested, next item hits the limit.
        write_reg(brf_pkg::CFG_LIMIT, 63'd1);
        send_start(-ONE, 3 * ONE, -ONE, 3 * ONE);
        send_value(ONE);
        // A limit of zero finishes on the start item itself.
        write_reg(brf_pkg::CFG_LIMIT, 63'd0);
        send_start(-ONE, 3 * ONE, -ONE, 3 * ONE);
        write_reg(brf_pkg::CFG_LIMIT, 63'd100);
    endtask

    // Random well-formed searches under a range of tolerance and limit settings.
    task automatic test_tolerance_settings();
        logic [62:0] abs_set[6], rel_set[6];
        logic [15:0] lim_set[6];
        abs_set = '{63'd1099511, 63'd0, {63{1'b1}}, 63'd0, 63'd1024,
                    63'({$urandom, $urandom})};
        rel_set = '{63'd1099511, 63'd0, 63'd0, {63{1'b1}}, 63'd0,
                    63'({$urandom, $urandom})};
        lim_set = '{16'd100, 16'd65535, 16'd100, 16'd40, 16'd7, 16'($urandom)};
        for (int p = 0; p < 6; p++) begin
            write_reg(brf_pkg::CFG_ABS_TOL, abs_set[p]);
            write_reg(brf_pkg::CFG_REL_TOL, rel_set[p]);
            write_reg(brf_pkg::CFG_LIMIT, 63'(lim_set[p]));
            for (int base = items_sent; items_sent - base < 230; )
                random_search($urandom_range(5, 60));
        end
        write_reg(brf_pkg::CFG_ABS_TOL, 63'd1099511);
        write_reg(brf_pkg::CFG_REL_TOL, 63'd1099511);
        write_reg(brf_pkg::CFG_LIMIT, 63'd30);
    endtask

    // Raw random items: fully random starts, stray value items and searches
    // cut short, so that every input bit takes both values.
    task automatic test_broken_sequences();
        for (int i = 0; i < 250; i++) begin
            case ($urandom_range(0, 3))
                0: send_start(rand_word(64), rand_word(64), rand_word(64), rand_word(64));
                1: send_value(rand_word(64));
                2: random_search($urandom_range(1, 4));
                default: send_start(rand_word(64), rand_word(64),
                                    rand_word($urandom_range(1, 64)), 0);
            endcase
        end
    endtask

    // Back to back items with the receiver always ready.
    task automatic test_back_to_back();
        drain();
        no_idle = 1;
        for (int base = items_sent; items_sent - base < 150; )
            random_search($urandom_range(10, 40));
        drain();
        no_idle = 0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_cases();
        test_tolerance_settings();
        test_broken_sequences();
        test_back_to_back();
        drain();
        $display("Covered %0d items, %0d results checked, register extremes included.",
                 items_sent, results_seen);
        $display("Results by status: eval %0d, converged %0d, no sign %0d, exact %0d, limit %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Generous bound: every item at its slowest with full stalls on both sides.
    initial begin
        #(80_000_000);
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

### brent_root_finder_step.f
hw/rtl/brf_pkg.sv
hw/rtl/brf_mdu.sv
hw/rtl/brent_root_finder_step.sv
hw/rtl/brf_checker.sv
tb/sv/brent_root_finder_step_test.sv
